/* rtl/core/log_linear_latency_histogram_macros.svh */
// assertion helpers for the latency histogram
`ifndef LOG_LINEAR_LATENCY_HISTOGRAM_MACROS_SVH
`define LOG_LINEAR_LATENCY_HISTOGRAM_MACROS_SVH

// same-cycle implication, checked only out of reset
`define LLH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked only out of reset
`define LLH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/llh_pkg.sv */
package llh_pkg;

  // fixed field widths
  localparam int unsigned ValW     = 48;
  localparam int unsigned RatioW   = 17;
  localparam int unsigned TotOutW  = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned RatioOne = 65536;

  // default configuration
  localparam int unsigned DefSubBucketBits = 5;
  localparam int unsigned DefBucketCount   = 512;
  localparam int unsigned DefCountWidth    = 32;

  // opcodes
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

/* rtl/core/log_linear_latency_histogram.sv */
// Log-linear latency histogram with percentile queries.
// Input channel (in_valid_i / in_ready_o) carries one transaction: opcode_i = add
// records sample_us_i into its bucket (negative samples are dropped), opcode_i =
// query returns the upper bound of the bucket that holds the ratio_q16_i fraction
// of all samples, or -1 on an empty histogram. Output channel (out_valid_o /
// out_ready_i) returns exactly one transaction per input transaction.
// An add passes a one-bit-per-cycle normalizing shifter while the sample is at
// least twice the sub-bucket count, then a read-modify-write of the counter
// memory, which has one write port and one registered read port. A query forms
// the target rank in an msb-first shift-add multiplier, sets the target, walks
// the counter memory one bucket per cycle, forms the bucket's upper bound and
// delivers. A dropped negative sample or a query on an empty histogram goes
// straight to delivery. One transaction is in work at a time; in_ready_o is low meanwhile.
// After reset the block clears the counter memory and holds in_ready_o low
// during that pass. A finished result sits in the output register; if the
// receiver stalls, the next transaction is still accepted and processed, and
// waits only at delivery until the output register is free.
module log_linear_latency_histogram
  import llh_pkg::*;
#(
  parameter int unsigned SUB_BUCKET_BITS = DefSubBucketBits,
  parameter int unsigned BUCKET_COUNT    = DefBucketCount,
  parameter int unsigned COUNT_WIDTH     = DefCountWidth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      opcode_i,
  input  logic signed [ValW-1:0]    sample_us_i,
  input  logic [RatioW-1:0]         ratio_q16_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [ValW-1:0]    percentile_value_o,
  output logic                      sample_taken_o,
  output logic [TotOutW-1:0]        total_count_o
);

  `include "log_linear_latency_histogram_macros.svh"

  localparam int unsigned SBB    = SUB_BUCKET_BITS;
  localparam int unsigned CW     = COUNT_WIDTH;
  localparam int unsigned IDX_W  = $clog2(BUCKET_COUNT);
  localparam int unsigned PTR_W  = IDX_W + 1;
  localparam int unsigned FULL_W = 6 + SBB + IDX_W;
  localparam int unsigned EXT_W  = IDX_W + SBB;
  localparam int unsigned ACC_W  = CW + RatioW;
  localparam int unsigned MCNT_W = $clog2(RatioW);
  localparam int unsigned S_LIM  = ValW - 2 - SBB;

  localparam logic [IDX_W-1:0]  LastIdx  = IDX_W'(BUCKET_COUNT - 1);
  localparam logic [FULL_W-1:0] LastFull = FULL_W'(BUCKET_COUNT - 1);
  localparam logic [PTR_W-1:0]  PtrEnd   = PTR_W'(BUCKET_COUNT);
  localparam logic [MCNT_W-1:0] MulLast  = MCNT_W'(RatioW - 1);
  localparam logic [ValW-1:0]   ValMax   = {1'b0, {(ValW-1){1'b1}}};

  // sequencer states
  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_NORM  = 4'd2;
  localparam logic [3:0] ST_RD    = 4'd3;
  localparam logic [3:0] ST_WR    = 4'd4;
  localparam logic [3:0] ST_MUL   = 4'd5;
  localparam logic [3:0] ST_TGT   = 4'd6;
  localparam logic [3:0] ST_WALK  = 4'd7;
  localparam logic [3:0] ST_BOUND = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;

  // upper bound of a bucket, saturated to the largest positive sample
  function automatic logic [ValW-1:0] bucket_bound(input logic [IDX_W-1:0] idx);
    logic [EXT_W-1:0] ext;
    logic [EXT_W-1:0] sh;
    logic [ValW-1:0]  mant;
    logic [ValW-1:0]  ones;
    ext  = EXT_W'(idx);
    sh   = (ext >> SBB) - EXT_W'(1);
    mant = ValW'({1'b1, ext[SBB-1:0]});
    ones = (ValW'(1) << sh[5:0]) - ValW'(1);
    if ((ext >> SBB) == '0) begin
      bucket_bound = ValW'(idx);
    end else if (sh > EXT_W'(S_LIM)) begin
      bucket_bound = ValMax;
    end else begin
      bucket_bound = (mant << sh[5:0]) | ones;
    end
  endfunction

  logic [3:0]         state_q, state_d;
  logic [ValW-1:0]    v_q, v_d;
  logic [5:0]         s_q, s_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [CW-1:0]      total_q, total_d;
  logic [RatioW-1:0]  r_q, r_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [MCNT_W-1:0]  mcnt_q, mcnt_d;
  logic [CW-1:0]      target_q, target_d;
  logic [CW-1:0]      seen_q, seen_d;
  logic [PTR_W-1:0]   ptr_q, ptr_d;
  logic [IDX_W-1:0]   cur_q, cur_d;
  logic               pend_q, pend_d;
  logic [ValW-1:0]    pval_q, pval_d;
  logic               taken_q, taken_d;
  logic               out_valid_q, out_valid_d;
  logic [ValW-1:0]    out_pval_q, out_pval_d;
  logic               out_taken_q, out_taken_d;
  logic [CW-1:0]      out_total_q, out_total_d;

  logic [CW-1:0]      bucket_mem_q [BUCKET_COUNT];
  logic [CW-1:0]      rd_data_q;
  logic [IDX_W-1:0]   rd_addr;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [CW-1:0]      mem_wdata;

  logic               in_fire;
  logic [FULL_W-1:0]  idx_full;
  logic [CW:0]        seen_sum;
  logic [CW-1:0]      seen_sat;
  logic [CW:0]        floor_v;
  logic [CW+31:0]     tot_ext;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // bucket index of the normalized sample
  always_comb begin
    if (v_q[ValW-1:SBB] == '0) begin
      idx_full = FULL_W'(v_q[SBB-1:0]);
    end else begin
      idx_full = FULL_W'({s_q + 6'd1, v_q[SBB-1:0]});
    end
  end

  // saturating running sum of the walk
  assign seen_sum = {1'b0, seen_q} + {1'b0, rd_data_q};
  assign seen_sat = seen_sum[CW] ? {CW{1'b1}} : seen_sum[CW-1:0];
  assign floor_v  = acc_q[ACC_W-1:FracBits];

  // sequencer
  always_comb begin
    state_d     = state_q;
    v_d         = v_q;
    s_d         = s_q;
    idx_d       = idx_q;
    total_d     = total_q;
    r_d         = r_q;
    acc_d       = acc_q;
    mcnt_d      = mcnt_q;
    target_d    = target_q;
    seen_d      = seen_q;
    ptr_d       = ptr_q;
    cur_d       = cur_q;
    pend_d      = pend_q;
    pval_d      = pval_q;
    taken_d     = taken_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_pval_d  = out_pval_q;
    out_taken_d = out_taken_q;
    out_total_d = out_total_q;
    rd_addr     = ptr_q[IDX_W-1:0];
    mem_we      = 1'b0;
    mem_waddr   = ptr_q[IDX_W-1:0];
    mem_wdata   = '0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (ptr_q[IDX_W-1:0] == LastIdx) begin
          ptr_d   = '0;
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q + PTR_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          pval_d  = '0;
          taken_d = 1'b0;
          if (opcode_i == OP_ADD) begin
            if (sample_us_i[ValW-1]) begin
              state_d = ST_FIN;
            end else begin
              v_d     = sample_us_i;
              s_d     = '0;
              state_d = ST_NORM;
            end
          end else if (total_q == '0) begin
            pval_d  = '1;
            state_d = ST_FIN;
          end else begin
            r_d     = (ratio_q16_i > RatioW'(RatioOne)) ? RatioW'(RatioOne) : ratio_q16_i;
            acc_d   = '0;
            mcnt_d  = '0;
            state_d = ST_MUL;
          end
        end
      end
      ST_NORM: begin
        // one bit a cycle until the sample sits below twice the sub-bucket count
        if (v_q[ValW-1:SBB+1] == '0) begin
          idx_d   = (idx_full > LastFull) ? LastIdx : idx_full[IDX_W-1:0];
          state_d = ST_RD;
        end else begin
          v_d = v_q >> 1;
          s_d = s_q + 6'd1;
        end
      end
      ST_RD: begin
        rd_addr = idx_q;
        state_d = ST_WR;
      end
      ST_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = (rd_data_q == '1) ? rd_data_q : rd_data_q + CW'(1);
        total_d   = (total_q == '1) ? total_q : total_q + CW'(1);
        taken_d   = 1'b1;
        state_d   = ST_FIN;
      end
      ST_MUL: begin
        // msb-first shift-add of ratio times total
        acc_d  = {acc_q[ACC_W-2:0], 1'b0} + (r_q[RatioW-1] ? ACC_W'(total_q) : '0);
        r_d    = r_q << 1;
        mcnt_d = mcnt_q + MCNT_W'(1);
        if (mcnt_q == MulLast) begin
          state_d = ST_TGT;
        end
      end
      ST_TGT: begin
        target_d = (floor_v >= {1'b0, total_q}) ? total_q : floor_v[CW-1:0] + CW'(1);
        seen_d   = '0;
        ptr_d    = '0;
        pend_d   = 1'b0;
        state_d  = ST_WALK;
      end
      ST_WALK: begin
        // stream reads one bucket ahead of the accumulate
        if (ptr_q < PtrEnd) begin
          ptr_d  = ptr_q + PTR_W'(1);
          cur_d  = ptr_q[IDX_W-1:0];
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          seen_d = seen_sat;
          if (seen_sat >= target_q || cur_q == LastIdx) begin
            idx_d   = cur_q;
            state_d = ST_BOUND;
          end
        end
      end
      ST_BOUND: begin
        pval_d  = bucket_bound(idx_q);
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_pval_d  = pval_q;
          out_taken_d = taken_q;
          out_total_d = total_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      pend_q      <= pend_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    v_q         <= v_d;
    s_q         <= s_d;
    idx_q       <= idx_d;
    r_q         <= r_d;
    acc_q       <= acc_d;
    mcnt_q      <= mcnt_d;
    target_q    <= target_d;
    seen_q      <= seen_d;
    cur_q       <= cur_d;
    pval_q      <= pval_d;
    taken_q     <= taken_d;
    out_pval_q  <= out_pval_d;
    out_taken_q <= out_taken_d;
    out_total_q <= out_total_d;
  end

  // bucket counter memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bucket_mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= bucket_mem_q[rd_addr];
  end

  assign tot_ext            = {32'b0, out_total_q};
  assign out_valid_o        = out_valid_q;
  assign percentile_value_o = out_pval_q;
  assign sample_taken_o     = out_taken_q;
  assign total_count_o      = tot_ext[TotOutW-1:0];

  `LLH_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready_o, "ready right after a transaction")
  `LLH_ASSERT_NOW(a_add_value_zero, out_valid_o && sample_taken_o, percentile_value_o == '0,
                  "recorded add carries a nonzero value")
  `LLH_ASSERT_NOW(a_walk_target, state_q == ST_WALK, target_q != '0 && target_q <= total_q,
                  "walk target out of range")

endmodule
